### rtl/segh_pkg.sv
// Shared widths and constants for the spring energy/gradient/Hessian kernel.
// No dependencies; imported by the channel interfaces and the kernel top level.
`timescale 1ns / 1ps
`default_nettype none

package segh_pkg;

  // Field widths of the channels
  localparam int unsigned CoordW  = 32;
  localparam int unsigned EnergyW = 47;
  localparam int unsigned OutW    = 40;

  // Internal widths
  localparam int unsigned LenW  = 34;  // spring length, Q.16
  localparam int unsigned KeW   = 48;  // effective stiffness, Q.16
  localparam int unsigned KaeW  = 82;  // ke * |L - r|
  localparam int unsigned TermW = 61;  // Hessian term magnitude incl. cap

  // Segmented multiplier operand and product widths
  localparam int unsigned MulAW = 96;
  localparam int unsigned MulBW = 64;
  localparam int unsigned MulPW = 160;

  localparam logic [OutW-1:0]    PosMax    = 40'h7F_FFFF_FFFF;
  localparam logic [OutW-1:0]    NegMag    = 40'h80_0000_0000;
  localparam logic [EnergyW-1:0] EnergyMax = '1;
  localparam logic [TermW-1:0]   TermCap   = 61'h1000_0000_0000_0000;

  // Row and column of the six distinct Hessian entries: xx xy xz yy yz zz
  localparam logic [5:0][1:0] HessA = {2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd0};
  localparam logic [5:0][1:0] HessB = {2'd2, 2'd2, 2'd1, 2'd2, 2'd1, 2'd0};

endpackage

`default_nettype wire

### rtl/segh_in_if.sv
// Input channel of the spring kernel: endpoints, stiffness, rest length.
// Depends on segh_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface segh_in_if import segh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] a_x;
  logic signed [CoordW-1:0] a_y;
  logic signed [CoordW-1:0] a_z;
  logic signed [CoordW-1:0] b_x;
  logic signed [CoordW-1:0] b_y;
  logic signed [CoordW-1:0] b_z;
  logic        [CoordW-1:0] stiffness;
  logic        [CoordW-1:0] rest_length;

  modport source (
    output valid, a_x, a_y, a_z, b_x, b_y, b_z, stiffness, rest_length,
    input  ready
  );

  modport sink (
    input  valid, a_x, a_y, a_z, b_x, b_y, b_z, stiffness, rest_length,
    output ready
  );
endinterface

`default_nettype wire

### rtl/segh_out_if.sv
// Result channel of the spring kernel: energy, gradient, Hessian, flag.
// Depends on segh_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface segh_out_if import segh_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [EnergyW-1:0]     energy;
  logic signed [OutW-1:0] grad_x;
  logic signed [OutW-1:0] grad_y;
  logic signed [OutW-1:0] grad_z;
  logic signed [OutW-1:0] hess_xx;
  logic signed [OutW-1:0] hess_xy;
  logic signed [OutW-1:0] hess_xz;
  logic signed [OutW-1:0] hess_yy;
  logic signed [OutW-1:0] hess_yz;
  logic signed [OutW-1:0] hess_zz;
  logic                   degenerate;

  modport source (
    output valid, energy, grad_x, grad_y, grad_z,
    output hess_xx, hess_xy, hess_xz, hess_yy, hess_yz, hess_zz, degenerate,
    input  ready
  );

  modport sink (
    input  valid, energy, grad_x, grad_y, grad_z,
    input  hess_xx, hess_xy, hess_xz, hess_yy, hess_yz, hess_zz, degenerate,
    output ready
  );
endinterface

`default_nettype wire

### rtl/segh_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Standalone; used by the spring kernel top level.
`timescale 1ns / 1ps
`default_nettype none

module segh_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 32,
  parameter int unsigned QuoW = 48
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [QuoW-1:0] quo_o,
  output logic            ovf_o
);

  localparam int unsigned RemW = (NumW > DenW + QuoW) ? NumW : DenW + QuoW;

  logic [RemW-1:0] rem_q [0:QuoW];
  logic [DenW-1:0] den_q [0:QuoW];
  logic [QuoW-1:0] quo_q [0:QuoW];
  logic            ovf_q [0:QuoW];

  // Quotient would not fit (also taken for a zero divisor)
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RemW'(num_i);
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      ovf_q[0] <= RemW'(num_i) >= (RemW'(den_i) << QuoW);
    end
  end

  for (genvar s = 1; s <= QuoW; s++) begin : g_step
    localparam int unsigned Bit = QuoW - s;
    logic [RemW-1:0] trial;

    assign trial = RemW'(den_q[s-1]) << Bit;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_q[s-1] >= trial) begin
          rem_q[s] <= rem_q[s-1] - trial;
          quo_q[s] <= quo_q[s-1] | (QuoW'(1) << Bit);
        end else begin
          rem_q[s] <= rem_q[s-1];
          quo_q[s] <= quo_q[s-1];
        end
        den_q[s] <= den_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
      end
    end
  end

  assign quo_o = quo_q[QuoW];
  assign ovf_o = ovf_q[QuoW];

endmodule

`default_nettype wire

### rtl/spring_energy_gradient_hessian.sv
// Spring kernel: energy, gradient and Hessian of one spring, Q16.16 fixed point.
// One item per cycle sustained while no result waits at the output.
// Depth is set by the 61-bit Hessian dividers, 62 stages after a 57-stage front.
// A stalled result freezes the whole pipeline; input is taken whenever it moves.
// Reset clears the valid bits only. Depends on segh_pkg, segh_in_if, segh_out_if,
// segh_div.
`timescale 1ns / 1ps
`default_nettype none

module spring_energy_gradient_hessian import segh_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  segh_in_if.sink   item_i,
  segh_out_if.source result_o
);

  localparam int unsigned Lat     = 121;
  localparam int unsigned SqSteps = LenW;
  localparam int unsigned SqW     = 69;

  // Stage at whose input each step is formed
  localparam int unsigned StLen  = 40;
  localparam int unsigned StKe   = 51;
  localparam int unsigned StMulA = 51;
  localparam int unsigned StMulB = 54;
  localparam int unsigned StKae  = 55;
  localparam int unsigned StDiv  = 57;
  localparam int unsigned StEn   = 58;
  localparam int unsigned StGrad = 99;
  localparam int unsigned StTerm = 120;
  localparam int unsigned StOut  = 121;

  // Multiplier sites
  localparam int unsigned NumMul = 23;
  localparam int unsigned MulSq  = 0;   // three squares
  localparam int unsigned MulKae = 3;
  localparam int unsigned MulKr  = 4;
  localparam int unsigned MulL2  = 5;
  localparam int unsigned MulPd  = 6;   // six products |d_a|*|d_b|
  localparam int unsigned MulEn  = 12;
  localparam int unsigned MulGn  = 13;  // three gradient numerators
  localparam int unsigned MulL3  = 16;
  localparam int unsigned MulT2n = 17;  // six Hessian numerators

  typedef struct packed {
    logic [2:0][CoordW-1:0] ad;
    logic [2:0]             dneg;
    logic [CoordW-1:0]      k;
    logic [CoordW-1:0]      r;
    logic [LenW-1:0]        len;
    logic [KeW-1:0]         ke;
    logic [LenW-1:0]        ae;
    logic                   eneg;
    logic                   ezero;
    logic                   degen;
    logic [KaeW-1:0]        kae;
    logic [EnergyW-1:0]     energy;
    logic [2:0][OutW-1:0]   grad;
    logic [TermW:0]         t1;
    logic [5:0][TermW:0]    t2;
    logic [5:0][OutW-1:0]   hess;
  } pipe_t;

  logic             adv;
  logic [Lat:1]     vld_q;
  pipe_t            pipe_d [1:Lat];
  pipe_t            pipe_q [1:Lat];

  logic [2:0][CoordW-1:0] pa;
  logic [2:0][CoordW-1:0] pb;

  logic [MulAW-1:0] mul_a [NumMul];
  logic [MulBW-1:0] mul_b [NumMul];
  logic [MulPW-1:0] mul_p [NumMul];

  logic [SqW-1:0]   sq_rem_q  [0:SqSteps];
  logic [LenW-1:0]  sq_root_q [0:SqSteps];

  logic [KeW-1:0]         ke_quo;
  logic                   ke_ovf;
  logic [2:0][OutW-1:0]   grad_quo;
  logic [2:0]             grad_ovf;
  logic [TermW-1:0]       t1_quo;
  logic                   t1_ovf;
  logic [5:0][TermW-1:0]  t2_quo;
  logic [5:0]             t2_ovf;

  // Advance everything unless a result waits at the output
  assign adv          = !vld_q[Lat] || result_o.ready;
  assign item_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-1:1], item_i.valid};
    end
  end

  assign pa = {item_i.a_z, item_i.a_y, item_i.a_x};
  assign pb = {item_i.b_z, item_i.b_y, item_i.b_x};

  // ---------------------------------------------------------------------------
  // Stage registers
  // ---------------------------------------------------------------------------
  for (genvar s = 1; s <= Lat; s++) begin : g_stage
    if (s == 1) begin : g_first
      always_comb begin
        logic [CoordW:0] d;
        pipe_d[s] = '0;
        for (int i = 0; i < 3; i++) begin
          d = {pa[i][CoordW-1], pa[i]} - {pb[i][CoordW-1], pb[i]};
          pipe_d[s].dneg[i] = d[CoordW];
          pipe_d[s].ad[i]   = d[CoordW] ? CoordW'((CoordW+1)'(0) - d) : d[CoordW-1:0];
        end
        pipe_d[s].k = item_i.stiffness;
        pipe_d[s].r = item_i.rest_length;
      end
    end else if (s == StLen) begin : g_len
      always_comb begin
        pipe_d[s]     = pipe_q[s-1];
        pipe_d[s].len = sq_root_q[SqSteps];
      end
    end else if (s == StKe) begin : g_ke
      always_comb begin
        logic [LenW:0] e;
        pipe_d[s]       = pipe_q[s-1];
        e               = {1'b0, pipe_q[s-1].len} - (LenW+1)'(pipe_q[s-1].r);
        pipe_d[s].eneg  = e[LenW];
        pipe_d[s].ae    = e[LenW] ? LenW'((LenW+1)'(0) - e) : e[LenW-1:0];
        pipe_d[s].ezero = (e == '0);
        pipe_d[s].degen = (pipe_q[s-1].len == '0);
        pipe_d[s].ke    = ke_ovf ? '1 : ke_quo;
      end
    end else if (s == StKae) begin : g_kae
      always_comb begin
        pipe_d[s]     = pipe_q[s-1];
        pipe_d[s].kae = mul_p[MulKae][KaeW-1:0];
      end
    end else if (s == StEn) begin : g_en
      always_comb begin
        logic [115:0] en;
        pipe_d[s] = pipe_q[s-1];
        en        = mul_p[MulEn][115:0];
        pipe_d[s].energy = (|en[115:80]) ? EnergyMax : en[79:33];
      end
    end else if (s == StGrad) begin : g_grad
      always_comb begin
        logic            neg;
        logic [OutW-1:0] cap;
        logic [OutW-1:0] mag;
        pipe_d[s] = pipe_q[s-1];
        for (int i = 0; i < 3; i++) begin
          neg = pipe_q[s-1].eneg ^ pipe_q[s-1].dneg[i];
          cap = neg ? NegMag : PosMax;
          mag = (grad_ovf[i] || grad_quo[i] > cap) ? cap : grad_quo[i];
          if (pipe_q[s-1].ad[i] == '0 || pipe_q[s-1].ezero) begin
            pipe_d[s].grad[i] = '0;
          end else begin
            pipe_d[s].grad[i] = neg ? (OutW'(0) - mag) : mag;
          end
        end
      end
    end else if (s == StTerm) begin : g_term
      always_comb begin
        logic [TermW-1:0] t1m;
        logic [TermW-1:0] t2m;
        logic             neg2;
        pipe_d[s] = pipe_q[s-1];
        t1m = (t1_ovf || t1_quo > TermCap) ? TermCap : t1_quo;
        pipe_d[s].t1 = pipe_q[s-1].eneg ? ((TermW+1)'(0) - {1'b0, t1m}) : {1'b0, t1m};
        for (int o = 0; o < 6; o++) begin
          neg2 = pipe_q[s-1].dneg[HessA[o]] ^ pipe_q[s-1].dneg[HessB[o]];
          t2m  = (t2_ovf[o] || t2_quo[o] > TermCap) ? TermCap : t2_quo[o];
          pipe_d[s].t2[o] = neg2 ? ((TermW+1)'(0) - {1'b0, t2m}) : {1'b0, t2m};
        end
      end
    end else if (s == StOut) begin : g_out
      always_comb begin
        logic [TermW+1:0] hs;
        pipe_d[s] = pipe_q[s-1];
        for (int o = 0; o < 6; o++) begin
          hs = ((HessA[o] == HessB[o]) ? {pipe_q[s-1].t1[TermW], pipe_q[s-1].t1}
                                       : (TermW+2)'(0))
             + {pipe_q[s-1].t2[o][TermW], pipe_q[s-1].t2[o]};
          if (hs[TermW+1:OutW-1] == {(TermW-OutW+3){hs[OutW-1]}}) begin
            pipe_d[s].hess[o] = hs[OutW-1:0];
          end else begin
            pipe_d[s].hess[o] = hs[TermW+1] ? NegMag : PosMax;
          end
        end
        // Coincident endpoints: drop gradient and Hessian
        if (pipe_q[s-1].degen) begin
          pipe_d[s].grad = '0;
          pipe_d[s].hess = '0;
        end
      end
    end else begin : g_pass
      always_comb begin
        pipe_d[s] = pipe_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        pipe_q[s] <= pipe_d[s];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Segmented multipliers: 32x32 partial products, row sums, final sum
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < 3; i++) begin : g_sq_ops
    assign mul_a[MulSq+i] = MulAW'(pipe_q[1].ad[i]);
    assign mul_b[MulSq+i] = MulBW'(pipe_q[1].ad[i]);
  end

  assign mul_a[MulKae] = MulAW'(pipe_q[StMulA].ke);
  assign mul_b[MulKae] = MulBW'(pipe_q[StMulA].ae);
  assign mul_a[MulKr]  = MulAW'(pipe_q[StMulA].ke);
  assign mul_b[MulKr]  = MulBW'(pipe_q[StMulA].r);
  assign mul_a[MulL2]  = MulAW'(pipe_q[StMulA].len);
  assign mul_b[MulL2]  = MulBW'(pipe_q[StMulA].len);

  for (genvar o = 0; o < 6; o++) begin : g_pd_ops
    assign mul_a[MulPd+o]  = MulAW'(pipe_q[StMulA].ad[HessA[o]]);
    assign mul_b[MulPd+o]  = MulBW'(pipe_q[StMulA].ad[HessB[o]]);
    assign mul_a[MulT2n+o] = MulAW'(mul_p[MulKr][KeW-1:0]);
    assign mul_b[MulT2n+o] = mul_p[MulPd+o][MulBW-1:0];
  end

  assign mul_a[MulEn] = MulAW'(mul_p[MulKae][KaeW-1:0]);
  assign mul_b[MulEn] = MulBW'(pipe_q[StMulB].ae);

  for (genvar i = 0; i < 3; i++) begin : g_gn_ops
    assign mul_a[MulGn+i] = MulAW'(mul_p[MulKae][KaeW-1:0]);
    assign mul_b[MulGn+i] = MulBW'(pipe_q[StMulB].ad[i]);
  end

  assign mul_a[MulL3] = MulAW'(mul_p[MulL2][2*LenW-1:0]);
  assign mul_b[MulL3] = MulBW'(pipe_q[StMulB].len);

  for (genvar m = 0; m < NumMul; m++) begin : g_mul
    logic [2:0][1:0][63:0] pp_q;
    logic [1:0][127:0]     row_q;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 2; j++) begin
            pp_q[i][j] <= 64'(mul_a[m][32*i +: 32]) * 64'(mul_b[m][32*j +: 32]);
          end
        end
        for (int j = 0; j < 2; j++) begin
          row_q[j] <= {pp_q[2][j], pp_q[0][j]} + {32'd0, pp_q[1][j], 32'd0};
        end
        mul_p[m] <= MulPW'(row_q[0]) + {row_q[1], 32'd0};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Square root of the summed squares, one result bit per stage
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_rem_q[0]  <= SqW'(mul_p[MulSq][63:0]) + SqW'(mul_p[MulSq+1][63:0])
                    + SqW'(mul_p[MulSq+2][63:0]);
      sq_root_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < SqSteps; j++) begin : g_sqrt
    localparam int unsigned B = SqSteps - 1 - j;
    logic [SqW-1:0] trial;

    // (root + 2^B)^2 - root^2
    assign trial = (SqW'(sq_root_q[j]) << (B + 1)) + (SqW'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (sq_rem_q[j] >= trial) begin
          sq_rem_q[j+1]  <= sq_rem_q[j] - trial;
          sq_root_q[j+1] <= sq_root_q[j] | (LenW'(1) << B);
        end else begin
          sq_rem_q[j+1]  <= sq_rem_q[j];
          sq_root_q[j+1] <= sq_root_q[j];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Dividers
  // ---------------------------------------------------------------------------
  // Zero rest length divides by one in Q.16, leaving k unscaled
  segh_div #(
    .NumW (KeW),
    .DenW (CoordW),
    .QuoW (KeW)
  ) u_ke_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i ({pipe_q[1].k, 16'd0}),
    .den_i ((pipe_q[1].r == '0) ? CoordW'(32'h0001_0000) : pipe_q[1].r),
    .quo_o (ke_quo),
    .ovf_o (ke_ovf)
  );

  for (genvar i = 0; i < 3; i++) begin : g_grad_div
    segh_div #(
      .NumW (114),
      .DenW (LenW + 16),
      .QuoW (OutW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (mul_p[MulGn+i][113:0]),
      .den_i ({pipe_q[StDiv].len, 16'd0}),
      .quo_o (grad_quo[i]),
      .ovf_o (grad_ovf[i])
    );
  end

  segh_div #(
    .NumW (KaeW),
    .DenW (LenW),
    .QuoW (TermW)
  ) u_t1_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (pipe_q[StDiv].kae),
    .den_i (pipe_q[StDiv].len),
    .quo_o (t1_quo),
    .ovf_o (t1_ovf)
  );

  for (genvar o = 0; o < 6; o++) begin : g_t2_div
    segh_div #(
      .NumW (112),
      .DenW (3 * LenW),
      .QuoW (TermW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (mul_p[MulT2n+o][111:0]),
      .den_i (mul_p[MulL3][3*LenW-1:0]),
      .quo_o (t2_quo[o]),
      .ovf_o (t2_ovf[o])
    );
  end

  // ---------------------------------------------------------------------------
  // Result channel
  // ---------------------------------------------------------------------------
  assign result_o.valid      = vld_q[Lat];
  assign result_o.energy     = pipe_q[Lat].energy;
  assign result_o.grad_x     = pipe_q[Lat].grad[0];
  assign result_o.grad_y     = pipe_q[Lat].grad[1];
  assign result_o.grad_z     = pipe_q[Lat].grad[2];
  assign result_o.hess_xx    = pipe_q[Lat].hess[0];
  assign result_o.hess_xy    = pipe_q[Lat].hess[1];
  assign result_o.hess_xz    = pipe_q[Lat].hess[2];
  assign result_o.hess_yy    = pipe_q[Lat].hess[3];
  assign result_o.hess_yz    = pipe_q[Lat].hess[4];
  assign result_o.hess_zz    = pipe_q[Lat].hess[5];
  assign result_o.degenerate = pipe_q[Lat].degen;

endmodule

`default_nettype wire
